@@ hw/rtl/icy_pkg.sv @@
// ----------------------------------------------------------------------------
// ICY demux package
// Shared constants, controller states and control/status structures.
// ----------------------------------------------------------------------------
package icy_pkg;

   localparam int BlockCapDefault = 512;
   localparam int TitleCapDefault = 64;
   localparam int KeyLen          = 12;
   localparam int IntervalWidth   = 20;
   localparam int CountWidth      = 16;

   localparam logic [7:0] CharSemi   = 8'h3b;
   localparam logic [7:0] CharSquote = 8'h27;
   localparam logic [7:0] CharDquote = 8'h22;

   localparam logic [0:0] RegAudioInterval = 1'b0;

   typedef enum logic [1:0] {
      PH_SEARCH = 2'd0,
      PH_AFTER  = 2'd1,
      PH_VALUE  = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_CMP,
      ST_EMIT,
      ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic take;      // take a byte and process it
      logic cmp_clr;   // start compare sweep
      logic cmp_step;  // compare one char
      logic commit;    // install candidate as title
      logic emit_clr;  // start emit sweep
      logic emit_step; // advance emit pointer
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic block_end;  // processed byte ended a block with a candidate
      logic cmp_done;   // compare sweep finished
      logic differs;    // candidate differs from title
      logic emit_last;  // current emit char is the final one
   } status_type;

   function automatic logic [7:0] key_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:  c = 8'h73;
         4'd1:  c = 8'h74;
         4'd2:  c = 8'h72;
         4'd3:  c = 8'h65;
         4'd4:  c = 8'h61;
         4'd5:  c = 8'h6d;
         4'd6:  c = 8'h74;
         4'd7:  c = 8'h69;
         4'd8:  c = 8'h74;
         4'd9:  c = 8'h6c;
         4'd10: c = 8'h65;
         4'd11: c = 8'h3d;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
   endfunction

endpackage

@@ hw/rtl/icy_if.sv @@
// ----------------------------------------------------------------------------
// ICY demux channels
// Valid/ready channels for stream bytes and result items.
// ----------------------------------------------------------------------------
interface icy_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface icy_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_meta;
   logic [7:0]  title_char;
   logic        char_valid;
   logic        last;
   logic [15:0] title_count;
   modport source (output valid, output is_meta, output title_char, output char_valid,
                   output last, output title_count, input ready);
   modport sink   (input valid, input is_meta, input title_char, input char_valid,
                   input last, input title_count, output ready);
endinterface

@@ hw/rtl/icy_ctrl.sv @@
// ----------------------------------------------------------------------------
// ICY demux controller
// Sequences byte processing, title compare, and title emission.
// ----------------------------------------------------------------------------
module icy_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                emitting,
   output icy_pkg::cmd_type    cmd,
   input  icy_pkg::status_type sts
);

   icy_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= icy_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         icy_pkg::ST_IDLE: if (req_valid) state_in = icy_pkg::ST_STEP;
         icy_pkg::ST_STEP: begin
            if (sts.block_end) state_in = icy_pkg::ST_CMP;
            else state_in = icy_pkg::ST_OUT;
         end
         icy_pkg::ST_CMP: begin
            if (sts.cmp_done) begin
               if (sts.differs) state_in = icy_pkg::ST_EMIT;
               else state_in = icy_pkg::ST_OUT;
            end
         end
         icy_pkg::ST_EMIT: if (rsp_ready && sts.emit_last) state_in = icy_pkg::ST_IDLE;
         icy_pkg::ST_OUT:  if (rsp_ready) state_in = icy_pkg::ST_IDLE;
         default: state_in = icy_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      emitting  = 1'b0;
      unique case (state_ff)
         icy_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         icy_pkg::ST_STEP: cmd.cmp_clr = 1'b1;
         icy_pkg::ST_CMP: begin
            cmd.cmp_step = ~sts.cmp_done;
            cmd.commit   = sts.cmp_done & sts.differs;
            cmd.emit_clr = sts.cmp_done;
         end
         icy_pkg::ST_EMIT: begin
            rsp_valid      = 1'b1;
            emitting       = 1'b1;
            cmd.emit_step  = rsp_ready;
         end
         icy_pkg::ST_OUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

@@ hw/rtl/icy_datapath.sv @@
// ----------------------------------------------------------------------------
// ICY demux datapath
// Block framing, key search, value capture and title store.
// ----------------------------------------------------------------------------
module icy_datapath #(
   parameter int BLOCK_CAP = icy_pkg::BlockCapDefault,
   parameter int TITLE_CAP = icy_pkg::TitleCapDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [icy_pkg::IntervalWidth-1:0]    audio_interval,
   input  logic [7:0]                           stream_byte,
   input  icy_pkg::cmd_type                     cmd,
   output icy_pkg::status_type                  sts,
   output logic                                 is_meta,
   output logic [7:0]                           title_char,
   output logic [icy_pkg::CountWidth-1:0]       title_count,
   output logic                                 char_valid_last
);

   localparam int PW = $clog2(BLOCK_CAP + 1);
   localparam int TW = $clog2(TITLE_CAP);
   localparam int LW = $clog2(TITLE_CAP + 1);
   localparam int UW = 8 + 4;

   logic                            in_block_ff, in_block_in;
   logic [icy_pkg::IntervalWidth-1:0] audio_count_ff, audio_count_in;
   logic [7:0]                      units_ff, units_in;
   logic [UW-1:0]                   pos_ff, pos_in;
   logic [PW-1:0]                   stored_ff, stored_in;
   logic                            ovf_ff, ovf_in;
   logic                            ended_ff, ended_in;
   logic [3:0]                      key_ff, key_in;
   icy_pkg::phase_type              phase_ff, phase_in;
   logic [7:0]                      quote_ff, quote_in;
   logic [LW-1:0]                   cand_len_ff, cand_len_in;
   logic [LW-1:0]                   title_len_ff;
   logic [icy_pkg::CountWidth-1:0]  count_ff;
   logic                            meta_ff, meta_in;
   logic                            end_ff, end_in;
   logic [LW-1:0]                   ptr_ff, ptr_in;
   logic                            diff_ff;
   logic [7:0]                      cand_mem [TITLE_CAP];
   logic [7:0]                      title_mem [TITLE_CAP];
   logic [7:0]                      cand_rd_ff, title_rd_ff;
   logic                            cand_we;
   logic [TW-1:0]                   cand_wa;
   logic [7:0]                      lc;
   logic                            key_hit;
   logic [TW-1:0]                   ptr_idx;
   logic [TW-1:0]                   rd_idx;
   logic                            mismatch;
   logic                            cmp_done;
   logic                            emit_last;

   assign lc      = icy_pkg::to_lower(stream_byte);
   assign ptr_idx = ptr_ff[TW-1:0];
   assign rd_idx  = ptr_in[TW-1:0];
   assign cand_wa = cand_len_ff[TW-1:0];
   assign key_hit = (key_ff < 4'(icy_pkg::KeyLen)) && (lc == icy_pkg::key_char(key_ff));

   always_comb begin
      in_block_in    = in_block_ff;
      audio_count_in = audio_count_ff;
      units_in       = units_ff;
      pos_in         = pos_ff;
      stored_in      = stored_ff;
      ovf_in         = ovf_ff;
      ended_in       = ended_ff;
      key_in         = key_ff;
      phase_in       = phase_ff;
      quote_in       = quote_ff;
      cand_len_in    = cand_len_ff;
      meta_in        = meta_ff;
      end_in         = end_ff;
      cand_we        = 1'b0;
      if (cmd.take) begin
         end_in = 1'b0;
         if (audio_interval == '0) begin
            meta_in = 1'b0;
         end else if (!in_block_ff) begin
            if (audio_count_ff < audio_interval) begin
               audio_count_in = audio_count_ff + 1'b1;
               meta_in        = 1'b0;
            end else begin
               audio_count_in = '0;
               units_in       = stream_byte;
               pos_in         = '0;
               stored_in      = '0;
               ovf_in         = 1'b0;
               ended_in       = 1'b0;
               key_in         = '0;
               phase_in       = icy_pkg::PH_SEARCH;
               quote_in       = '0;
               cand_len_in    = '0;
               in_block_in    = (stream_byte != 8'd0);
               meta_in        = 1'b1;
            end
         end else begin
            meta_in = 1'b1;
            if (32'(stored_ff) + 1 < BLOCK_CAP) begin
               stored_in = stored_ff + 1'b1;
               if (!ended_ff) begin
                  if (stream_byte == 8'd0) begin
                     ended_in = 1'b1;
                  end else begin
                     unique case (phase_ff)
                        icy_pkg::PH_SEARCH: begin
                           if (key_hit) key_in = key_ff + 1'b1;
                           else key_in = (lc == icy_pkg::key_char(4'd0)) ? 4'd1 : 4'd0;
                           if (key_hit && key_ff == 4'(icy_pkg::KeyLen - 1))
                              phase_in = icy_pkg::PH_AFTER;
                        end
                        icy_pkg::PH_AFTER, icy_pkg::PH_VALUE: begin
                           phase_in = icy_pkg::PH_VALUE;
                           if (phase_ff == icy_pkg::PH_AFTER &&
                               (stream_byte == icy_pkg::CharSquote ||
                                stream_byte == icy_pkg::CharDquote)) begin
                              quote_in = stream_byte;
                           end else begin
                              logic [7:0] q;
                              q = (phase_ff == icy_pkg::PH_AFTER) ? 8'd0 : quote_ff;
                              quote_in = q;
                              if (q != 8'd0 && stream_byte == q) begin
                                 phase_in = icy_pkg::PH_DONE;
                              end else if (q == 8'd0 && stream_byte == icy_pkg::CharSemi) begin
                                 phase_in = icy_pkg::PH_DONE;
                              end else if (32'(cand_len_ff) + 1 < TITLE_CAP) begin
                                 cand_we     = 1'b1;
                                 cand_len_in = cand_len_ff + 1'b1;
                              end else begin
                                 phase_in = icy_pkg::PH_DONE;
                              end
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end else begin
               ovf_in = 1'b1;
            end
            pos_in = pos_ff + 1'b1;
            if (pos_in >= {units_ff, 4'd0}) begin
               in_block_in = 1'b0;
               stored_in   = '0;
               pos_in      = '0;
               end_in      = !ovf_in && cand_len_in != '0;
            end
         end
      end
   end

   // sweep pointer; memory reads are addressed by its next value so that the
   // registered read data lines up with ptr_ff
   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.cmp_clr || cmd.emit_clr) ptr_in = '0;
      else if (cmd.cmp_step || cmd.emit_step) ptr_in = ptr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_block_ff    <= 1'b0;
         audio_count_ff <= '0;
         units_ff       <= '0;
         pos_ff         <= '0;
         stored_ff      <= '0;
         ovf_ff         <= 1'b0;
         ended_ff       <= 1'b0;
         key_ff         <= '0;
         phase_ff       <= icy_pkg::PH_SEARCH;
         quote_ff       <= '0;
         cand_len_ff    <= '0;
         title_len_ff   <= '0;
         count_ff       <= '0;
         meta_ff        <= 1'b0;
         end_ff         <= 1'b0;
         ptr_ff         <= '0;
         diff_ff        <= 1'b0;
      end else begin
         in_block_ff    <= in_block_in;
         audio_count_ff <= audio_count_in;
         units_ff       <= units_in;
         pos_ff         <= pos_in;
         stored_ff      <= stored_in;
         ovf_ff         <= ovf_in;
         ended_ff       <= ended_in;
         key_ff         <= key_in;
         phase_ff       <= phase_in;
         quote_ff       <= quote_in;
         cand_len_ff    <= cand_len_in;
         meta_ff        <= meta_in;
         end_ff         <= end_in;
         ptr_ff         <= ptr_in;
         if (cmd.cmp_clr) diff_ff <= (cand_len_ff != title_len_ff);
         if (cmd.commit) begin
            title_len_ff <= cand_len_ff;
            count_ff     <= count_ff + 1'b1;
         end
      end
   end

   // compare sweep: lengths equal, so entries below the length are written in both
   assign mismatch  = (ptr_ff < cand_len_ff) && (cand_rd_ff != title_rd_ff);
   assign cmp_done  = diff_ff || mismatch || (ptr_ff == cand_len_ff);
   assign emit_last = (ptr_ff + 1'b1 == title_len_ff);

   assign sts = '{block_end: end_ff,
                  cmp_done:  cmp_done,
                  differs:   diff_ff || mismatch,
                  emit_last: emit_last};

   always_ff @(posedge clock) begin
      if (cand_we) cand_mem[cand_wa] <= stream_byte;
      cand_rd_ff <= cand_mem[rd_idx];
   end

   // title store is refreshed from the candidate as each char is emitted
   always_ff @(posedge clock) begin
      if (cmd.emit_step) title_mem[ptr_idx] <= cand_rd_ff;
      title_rd_ff <= title_mem[rd_idx];
   end

   assign is_meta         = meta_ff;
   assign title_char      = cand_rd_ff;
   assign title_count     = count_ff;
   assign char_valid_last = emit_last;

endmodule

@@ hw/rtl/icy_metadata_demux.sv @@
// ----------------------------------------------------------------------------
// ICY metadata demultiplexer
// Splits an ICY stream into audio and metadata bytes and tracks the title.
// ----------------------------------------------------------------------------
// Bytes are taken one at a time: a new item is accepted only once every result
// of the previous one has been taken. An ordinary byte gives one result,
// offered in the output state after the step state, and the block is ready
// again the cycle after that result is taken. A byte that closes a metadata
// block with a non-empty value first compares it with the stored title, one
// character a cycle from the store reads; the sweep ends at once when the
// lengths differ, otherwise at the first mismatch or after the last character.
// A new title then gives one result per character, one a cycle while the result
// side is ready; an unchanged one gives the single ordinary result.
module icy_metadata_demux #(
   parameter int BLOCK_CAP = icy_pkg::BlockCapDefault,
   parameter int TITLE_CAP = icy_pkg::TitleCapDefault
) (
   input  logic        clock,
   input  logic        reset,
   icy_req_if.sink     req,
   icy_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [icy_pkg::IntervalWidth-1:0] interval_ff;
   icy_pkg::cmd_type    cmd;
   icy_pkg::status_type sts;
   logic                emitting;
   logic                meta;
   logic [7:0]          ch;
   logic                emit_last;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == icy_pkg::RegAudioInterval) begin
         interval_ff <= csr_pwdata[icy_pkg::IntervalWidth-1:0];
      end
   end

   assign csr_prdata = (csr_paddr == icy_pkg::RegAudioInterval) ?
                       {12'd0, interval_ff} : 32'd0;

   icy_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .emitting  (emitting),
      .cmd       (cmd),
      .sts       (sts)
   );

   icy_datapath #(
      .BLOCK_CAP (BLOCK_CAP),
      .TITLE_CAP (TITLE_CAP)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .audio_interval  (interval_ff),
      .stream_byte     (req.stream_byte),
      .cmd             (cmd),
      .sts             (sts),
      .is_meta         (meta),
      .title_char      (ch),
      .title_count     (rsp.title_count),
      .char_valid_last (emit_last)
   );

   assign rsp.is_meta    = emitting | meta;
   assign rsp.title_char = emitting ? ch : 8'd0;
   assign rsp.char_valid = emitting;
   assign rsp.last       = emitting ? emit_last : 1'b1;

endmodule

@@ verif/icy_checker.sv @@
// ----------------------------------------------------------------------------
// ICY demux checker
// Watches the byte, result and register channels, predicts the result items
// of every accepted stream byte and compares them in order.
// ----------------------------------------------------------------------------
module icy_checker (
   input  logic        clock,
   input  logic        reset,
   icy_req_if          req,
   icy_rsp_if          rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending,
   output int          title_changes
);

   localparam int BlkCap = icy_pkg::BlockCapDefault;
   localparam int TtlCap = icy_pkg::TitleCapDefault;

   typedef struct {
      logic        is_meta;
      logic [7:0]  title_char;
      logic        char_valid;
      logic        last;
      logic [15:0] title_count;
   } demux_item_type;

   demux_item_type      want_q[$];
   logic [19:0]         interval;
   logic                in_blk;
   logic [19:0]         audio_cnt;
   logic [7:0]          units;
   logic [11:0]         pos;
   logic [12:0]         stored;
   logic                ovf;
   logic                ended;
   logic [3:0]          key_pos;
   icy_pkg::phase_type  phase;
   logic [7:0]          quote;
   logic [7:0]          cand[TtlCap];
   int                  cand_len;
   logic [7:0]          title[TtlCap];
   int                  title_len;
   logic [15:0]         changes;
   string               key_text = "streamtitle=";

   task automatic push_item(input logic meta, input logic [7:0] ch, input logic vld,
                            input logic lst);
      want_q.push_back('{meta, ch, vld, lst, changes});
   endtask

   task automatic take_value(input logic [7:0] c);
      if (quote != 8'h00 && c == quote) phase = icy_pkg::PH_DONE;
      else if (quote == 8'h00 && c == icy_pkg::CharSemi) phase = icy_pkg::PH_DONE;
      else if (cand_len + 1 < TtlCap) begin
         cand[cand_len] = c;
         cand_len++;
      end else phase = icy_pkg::PH_DONE;
   endtask

   task automatic scan_char(input logic [7:0] c);
      logic [7:0] lc;
      lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
      if (c == 8'h00) ended = 1'b1;
      else if (phase == icy_pkg::PH_SEARCH) begin
         if (key_pos < icy_pkg::KeyLen && lc == key_text[key_pos]) key_pos++;
         else key_pos = (lc == key_text[0]) ? 4'd1 : 4'd0;
         if (key_pos >= icy_pkg::KeyLen) phase = icy_pkg::PH_AFTER;
      end else if (phase == icy_pkg::PH_AFTER) begin
         phase = icy_pkg::PH_VALUE;
         if (c == icy_pkg::CharSquote || c == icy_pkg::CharDquote) quote = c;
         else begin
            quote = 8'h00;
            take_value(c);
         end
      end else if (phase == icy_pkg::PH_VALUE) take_value(c);
   endtask

   task automatic predict_byte(input logic [7:0] b);
      logic changed;
      changed = 1'b0;
      if (interval == 0) push_item(1'b0, 8'h00, 1'b0, 1'b1);
      else if (!in_blk) begin
         if (audio_cnt < interval) begin
            audio_cnt++;
            push_item(1'b0, 8'h00, 1'b0, 1'b1);
         end else begin
            audio_cnt = '0;
            units     = b;
            pos       = '0;
            stored    = '0;
            ovf       = 1'b0;
            ended     = 1'b0;
            key_pos   = '0;
            phase     = icy_pkg::PH_SEARCH;
            quote     = 8'h00;
            cand_len  = 0;
            in_blk    = (b != 8'h00);
            push_item(1'b1, 8'h00, 1'b0, 1'b1);
         end
      end else begin
         if (stored + 1 < BlkCap) begin
            stored++;
            if (!ended) scan_char(b);
         end else ovf = 1'b1;
         pos++;
         if (int'(pos) >= int'(units) * 16) begin
            in_blk = 1'b0;
            if (!ovf && cand_len > 0) begin
               changed = (cand_len != title_len);
               for (int i = 0; i < cand_len; i++) if (cand[i] != title[i]) changed = 1'b1;
               if (changed) begin
                  for (int i = 0; i < cand_len; i++) title[i] = cand[i];
                  title_len = cand_len;
                  changes++;
                  title_changes++;
               end
            end
            stored = '0;
            pos    = '0;
         end
         if (changed) begin
            for (int i = 0; i < title_len; i++)
               push_item(1'b1, title[i], 1'b1, i + 1 == title_len);
         end else push_item(1'b1, 8'h00, 1'b0, 1'b1);
      end
   endtask

   task automatic note_fail(input string what);
      fail_count++;
      if (fail_count <= 10) $display("mismatch: %s", what);
   endtask

   // handshakes settle by the falling edge and complete at the next rising one
   always @(negedge clock) begin
      demux_item_type w;
      if (reset) begin
         want_q.delete();
         interval = '0; in_blk = 1'b0; audio_cnt = '0; units = '0; pos = '0;
         stored = '0; ovf = 1'b0; ended = 1'b0; key_pos = '0; phase = icy_pkg::PH_SEARCH;
         quote = 8'h00; cand_len = 0; title_len = 0; changes = '0;
         fail_count = 0; title_changes = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == icy_pkg::RegAudioInterval)
            interval = csr_pwdata[19:0];
         if (req.valid && req.ready) predict_byte(req.stream_byte);
         if (rsp.valid && rsp.ready) begin
            if (want_q.size() == 0) note_fail("result item with none expected");
            else begin
               w = want_q.pop_front();
               if (rsp.is_meta !== w.is_meta || rsp.title_char !== w.title_char ||
                   rsp.char_valid !== w.char_valid || rsp.last !== w.last ||
                   rsp.title_count !== w.title_count)
                  note_fail($sformatf(
                     "exp meta=%0d ch=%02h cv=%0d last=%0d cnt=%0d, got %0d %02h %0d %0d %0d",
                     w.is_meta, w.title_char, w.char_valid, w.last, w.title_count,
                     rsp.is_meta, rsp.title_char, rsp.char_valid, rsp.last,
                     rsp.title_count));
            end
         end
      end
      pending = want_q.size();
   end
endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// ICY demux testbench
// Drives audio and metadata framing at several intervals with directed and
// random titles, random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int Limit = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [0:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count, pending, title_changes;
   int          cycles = 0, n_bytes = 0, n_blocks = 0;
   logic        calm = 1'b0, hold = 1'b0, hold_go = 1'b0;

   icy_req_if req ();
   icy_rsp_if rsp ();

   always #5 clock = ~clock;

   icy_metadata_demux DUT (
      .clock, .reset, .req, .rsp,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   icy_checker u_checker (
      .clock, .reset, .req, .rsp,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .fail_count, .pending, .title_changes
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > Limit) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock)
      rsp.ready <= !reset && !hold && (calm || $urandom_range(0, 99) >= 25);

   initial begin
      wait (hold_go);
      hold = 1'b1;
      repeat (400) @(posedge clock);
      hold = 1'b0;
   end

   task automatic send_byte(input logic [7:0] b);
      logic hs;
      if (!calm && $urandom_range(0, 99) < 25) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.stream_byte <= b;
      do begin
         @(negedge clock);
         hs = req.ready;
         @(posedge clock);
      end while (!hs);
      n_bytes++;
   endtask

   task automatic set_interval(input logic [19:0] v);
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= icy_pkg::RegAudioInterval;
      csr_pwdata <= {12'h000, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_audio(input int n);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
   endtask

   // one length byte, then units*16 bytes: text first, then NUL padding
   task automatic send_block(input string text, input int units);
      send_byte(units[7:0]);
      n_blocks++;
      for (int i = 0; i < units * 16; i++) send_byte(i < text.len() ? text[i] : 8'h00);
   endtask

   task automatic frame(input int interval, input string text, input int units);
      send_audio(interval);
      send_block(text, units);
   endtask

   function automatic string rand_title(input int n, input logic [7:0] avoid);
      string s;
      logic [7:0] c;
      s = "";
      for (int i = 0; i < n; i++) begin
         do c = 8'($urandom_range(32, 126)); while (c == avoid || c == icy_pkg::CharSemi);
         s = {s, string'(c)};
      end
      return s;
   endfunction

   initial begin
      req.valid = 1'b0;
      req.stream_byte = 8'h00;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // demux off: every byte passes as audio
      send_byte(8'h00); send_byte(8'hff); send_byte(8'h5a);
      set_interval(20'd2);
      calm <= 1'b1;
      frame(2, "StreamTitle=Hi;", 1);
      frame(2, "StreamTitle=Hi;", 1);
      frame(2, "stREAMtitle=\"Q\"", 1);
      calm <= 1'b0;
      // zero length byte: no block follows
      send_audio(2); send_byte(8'h00);
      n_blocks++;
      hold_go <= 1'b1;
      frame(2, "StreamTitle='';", 1);
      frame(2, "SStreamTitle=R", 1);
      calm <= 1'b1;
      frame(2, {"StreamTitle='", rand_title(66, icy_pkg::CharSquote), "'"}, 5);
      calm <= 1'b0;
      // interval lowered below the running audio count
      set_interval(20'hfffff);
      send_audio(3);
      set_interval(20'd1);
      send_block("StreamTitle=L", 1);

      req.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d stream bytes, %0d metadata blocks, %0d title changes",
               n_bytes, n_blocks, title_changes);
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results outstanding", fail_count, pending);
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
hw/rtl/icy_pkg.sv
hw/rtl/icy_if.sv
hw/rtl/icy_ctrl.sv
hw/rtl/icy_datapath.sv
hw/rtl/icy_metadata_demux.sv
verif/icy_checker.sv
verif/tb_top.sv
